### rtl/core/msx_pkg.sv
// ----------------------------------------------------------------------------
// MIDI SysEx command parser package
// Shared types, constants and reply byte tables for the parser core.
// ----------------------------------------------------------------------------
package msx_pkg;

    localparam logic [7:0] SYX_START  = 8'hF0;
    localparam logic [7:0] SYX_END    = 8'hF7;
    localparam logic [7:0] RT_MIN     = 8'hF8;
    localparam logic [7:0] MFR_ID     = 8'h7E;
    localparam logic [7:0] DEV_FAMILY = 8'h4E;
    localparam logic [7:0] LAYOUT_ONE = 8'h01;

    localparam logic [6:0] CMD_LAYOUT = 7'h00;
    localparam logic [6:0] CMD_NOP    = 7'h01;
    localparam logic [6:0] CMD_DISACK = 7'h0E;
    localparam logic [6:0] CMD_ACK    = 7'h0F;

    localparam logic [2:0] HDR_LEN  = 3'd5;
    localparam logic [2:0] HDR_DONE = 3'd6;

    // Results per input item; a longer reply carries its closing byte over.
    localparam logic [4:0] MAX_ITEMS = 5'd14;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MERGER_MODE_ON = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVALID_CMD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LED_COLOURS    = 3'd5;

    localparam int Q_AW = 1;
    localparam int QUEUE_DEPTH = 1 << Q_AW;

    typedef struct packed {
        logic [6:0] device_id;
        logic       merger_mode_on;
        logic [6:0] invalid_command_code;
        logic [6:0] grid_columns;
        logic [6:0] grid_rows;
        logic [6:0] led_colours;
    } t_cfg;

    typedef enum logic [1:0] {
        RPL_NONE   = 2'd0,
        RPL_ACK    = 2'd1,
        RPL_DISACK = 2'd2,
        RPL_LAYOUT = 2'd3
    } t_reply;

    // One classified input item, handed from the front to the back.
    typedef struct packed {
        logic       tail;    // closing 0xF7 of the previous reply goes first
        logic       footer;  // merger footer precedes the reply
        t_reply     reply;
        logic       empty;   // nothing to send: a single idle result
        logic       fwd;     // forwarding state after this input
        logic [3:0] count;   // number of results, 1 to 14
    } t_job;

    function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
        logic [7:0] b;
        case (pos)
            3'd0:    b = SYX_START;
            3'd1:    b = 8'h00;
            3'd2:    b = 8'h00;
            3'd3:    b = MFR_ID;
            default: b = DEV_FAMILY;
        endcase
        return b;
    endfunction

    function automatic logic [3:0] reply_len(input t_reply r);
        logic [3:0] n;
        case (r)
            RPL_ACK:    n = 4'd9;
            RPL_DISACK: n = 4'd9;
            RPL_LAYOUT: n = 4'd14;
            default:    n = 4'd0;
        endcase
        return n;
    endfunction

    // Byte j of a reply message, footer not counted.
    function automatic logic [7:0] msg_byte(input t_reply r, input logic [3:0] j,
                                            input t_cfg c);
        logic [7:0] b;
        b = SYX_END;
        if (j < {1'b0, HDR_LEN}) begin
            b = hdr_byte(j[2:0]);
        end else if (j == {1'b0, HDR_LEN}) begin
            b = {1'b0, c.device_id};
        end else if (r == RPL_LAYOUT) begin
            case (j)
                4'd6:    b = LAYOUT_ONE;
                4'd7:    b = {1'b0, c.grid_columns};
                4'd8:    b = {1'b0, c.grid_rows};
                4'd9:    b = {1'b0, c.led_colours};
                4'd10:   b = LAYOUT_ONE;
                4'd11:   b = LAYOUT_ONE;
                4'd12:   b = LAYOUT_ONE;
                default: b = SYX_END;
            endcase
        end else begin
            case (j)
                4'd6:    b = (r == RPL_ACK) ? {1'b0, CMD_ACK} : {1'b0, CMD_DISACK};
                4'd7:    b = (r == RPL_ACK) ? 8'h00 : {1'b0, c.invalid_command_code};
                default: b = SYX_END;
            endcase
        end
        return b;
    endfunction

endpackage

### rtl/core/msx_front.sv
// ----------------------------------------------------------------------------
// MIDI SysEx parser front end
// Matches the header and device ID, tracks the message and classifies each
// received byte into a reply job.
// ----------------------------------------------------------------------------
module msx_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  msx_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_midi_byte,
    output logic             o_job_valid,
    output msx_pkg::t_job    o_job,
    input  logic             i_job_ready
);
    import msx_pkg::*;

    logic [2:0] r_hpos, n_hpos;
    logic       r_own, n_own;
    logic       r_cseen, n_cseen;
    logic [6:0] r_code, n_code;
    logic       r_pseen, n_pseen;
    logic       r_fwd, n_fwd;
    logic       r_tail, n_tail;

    logic       bad;
    logic       fin;
    logic       footer;
    t_reply     reply;
    logic [4:0] total;
    logic       push;

    assign o_ready     = i_job_ready;
    assign o_job_valid = i_valid;
    assign push        = i_valid && i_job_ready;

    always_comb begin
        n_hpos  = r_hpos;
        n_own   = r_own;
        n_cseen = r_cseen;
        n_code  = r_code;
        n_pseen = r_pseen;
        n_fwd   = r_fwd;
        reply   = RPL_NONE;
        footer  = 1'b0;
        fin     = 1'b0;
        bad     = 1'b0;
        if (i_midi_byte < RT_MIN) begin
            if (!r_own) begin
                if (r_hpos < HDR_LEN) begin
                    bad = (i_midi_byte != hdr_byte(r_hpos));
                end else begin
                    bad = (i_midi_byte != {1'b0, i_cfg.device_id});
                end
                if (bad) begin
                    fin = 1'b1;
                end else if (r_hpos >= HDR_LEN) begin
                    n_hpos = HDR_DONE;
                    n_own  = 1'b1;
                    n_fwd  = 1'b0;
                end else begin
                    n_hpos = r_hpos + 3'd1;
                end
            end else if (i_midi_byte[7]) begin
                if (i_midi_byte == SYX_END && r_cseen) begin
                    case (r_code)
                        CMD_LAYOUT: begin
                            footer = i_cfg.merger_mode_on;
                            reply  = RPL_LAYOUT;
                        end
                        CMD_ACK: begin
                            // The footer goes out even when payload suppresses the ack.
                            footer = i_cfg.merger_mode_on;
                            if (!r_pseen) begin
                                reply = RPL_ACK;
                            end
                        end
                        CMD_NOP, CMD_DISACK: begin
                            reply = RPL_NONE;
                        end
                        default: begin
                            footer = i_cfg.merger_mode_on;
                            reply  = RPL_DISACK;
                        end
                    endcase
                end
                fin = 1'b1;
            end else if (!r_cseen) begin
                n_cseen = 1'b1;
                n_code  = i_midi_byte[6:0];
                case (i_midi_byte[6:0])
                    CMD_ACK: begin
                        n_pseen = 1'b0;
                    end
                    CMD_LAYOUT, CMD_NOP, CMD_DISACK: begin
                        n_pseen = r_pseen;
                    end
                    default: begin
                        footer = i_cfg.merger_mode_on;
                        reply  = RPL_DISACK;
                        fin    = 1'b1;
                    end
                endcase
            end else if (r_code == CMD_ACK) begin
                n_pseen = 1'b1;
            end
        end
        if (fin) begin
            n_hpos  = 3'd0;
            n_own   = 1'b0;
            n_cseen = 1'b0;
            n_code  = 7'd0;
            n_pseen = 1'b0;
            n_fwd   = 1'b1;
        end
    end

    assign total  = {4'd0, r_tail} + {4'd0, footer} + {1'b0, reply_len(reply)};
    assign n_tail = (total > MAX_ITEMS);

    always_comb begin
        o_job.tail   = r_tail;
        o_job.footer = footer;
        o_job.reply  = reply;
        o_job.empty  = (total == 5'd0);
        o_job.fwd    = n_fwd;
        if (n_tail) begin
            o_job.count = MAX_ITEMS[3:0];
        end else if (total == 5'd0) begin
            o_job.count = 4'd1;
        end else begin
            o_job.count = total[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hpos  <= 3'd0;
            r_own   <= 1'b0;
            r_cseen <= 1'b0;
            r_code  <= 7'd0;
            r_pseen <= 1'b0;
            r_fwd   <= 1'b1;
            r_tail  <= 1'b0;
        end else if (push) begin
            r_hpos  <= n_hpos;
            r_own   <= n_own;
            r_cseen <= n_cseen;
            r_code  <= n_code;
            r_pseen <= n_pseen;
            r_fwd   <= n_fwd;
            r_tail  <= n_tail;
        end
    end

endmodule

### rtl/core/msx_queue.sv
// ----------------------------------------------------------------------------
// MIDI SysEx parser job queue
// Small FIFO of classified jobs between the front end and the reply sender.
// ----------------------------------------------------------------------------
module msx_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  msx_pkg::t_job    i_job,
    output logic             o_valid,
    input  logic             i_ready,
    output msx_pkg::t_job    o_job
);
    import msx_pkg::*;

    t_job            r_mem [QUEUE_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;
    logic            push;
    logic            pop;

    assign o_ready = (r_cnt != QUEUE_DEPTH[Q_AW:0]);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + {{Q_AW{1'b0}}, 1'b1};
            end else if (pop && !push) begin
                r_cnt <= r_cnt - {{Q_AW{1'b0}}, 1'b1};
            end
        end
    end

endmodule

### rtl/core/msx_back.sv
// ----------------------------------------------------------------------------
// MIDI SysEx parser reply sender
// Expands one job into its result items, one per cycle while the output is not
// stalled, into an output register.
// ----------------------------------------------------------------------------
module msx_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  msx_pkg::t_cfg    i_cfg,
    input  logic             i_job_valid,
    output logic             o_job_ready,
    input  msx_pkg::t_job    i_job,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_tx_valid,
    output logic [7:0]       o_tx_byte,
    output logic             o_forward_enable,
    output logic             o_last
);
    import msx_pkg::*;

    t_job       r_job;
    logic       r_active;
    logic [3:0] r_k;
    logic       r_ov;
    logic       r_txv;
    logic [7:0] r_byte;
    logic       r_fwd;
    logic       r_last;

    logic       load_out;
    logic       emit;
    logic       job_last;
    logic       free;
    logic       take;
    logic [3:0] j;
    logic [7:0] item_byte;

    assign load_out    = !r_ov || i_ready;
    assign emit        = r_active && load_out;
    assign job_last    = (r_k == r_job.count - 4'd1);
    assign free        = !r_active || (emit && job_last);
    assign o_job_ready = free;
    assign take        = i_job_valid && free;

    // Position inside the reply once the carried-over byte is skipped.
    assign j = r_k - {3'd0, r_job.tail};

    always_comb begin
        if (r_job.empty) begin
            item_byte = 8'h00;
        end else if (r_job.tail && r_k == 4'd0) begin
            item_byte = SYX_END;
        end else if (r_job.footer && j == 4'd0) begin
            item_byte = SYX_END;
        end else begin
            item_byte = msg_byte(r_job.reply, j - {3'd0, r_job.footer}, i_cfg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_k      <= 4'd0;
            r_ov     <= 1'b0;
        end else begin
            if (take) begin
                r_active <= 1'b1;
                r_k      <= 4'd0;
            end else if (emit && job_last) begin
                r_active <= 1'b0;
            end else if (emit) begin
                r_k <= r_k + 4'd1;
            end
            if (load_out) begin
                r_ov <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= i_job;
        end
        if (emit) begin
            r_txv  <= !r_job.empty;
            r_byte <= item_byte;
            r_fwd  <= r_job.fwd;
            r_last <= job_last;
        end
    end

    assign o_valid          = r_ov;
    assign o_tx_valid       = r_txv;
    assign o_tx_byte        = r_byte;
    assign o_forward_enable = r_fwd;
    assign o_last           = r_last;

endmodule

### rtl/core/midi_sysex_command_parser_core.sv
// ----------------------------------------------------------------------------
// MIDI SysEx command parser core
// Parses received MIDI bytes for SysEx commands and produces reply bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_midi_byte) takes one MIDI byte per
//   transfer. Each input byte yields 1 to 14 result transfers on the output
//   channel (o_out_valid/i_out_ready); o_last marks the final one. A byte that
//   causes nothing to send gives one result with o_tx_valid low.
//   Jobs pass the job queue, the sender's job register and the output register.
//   Throughput: the reply sender emits one result per cycle while the receiver
//   accepts; most bytes have one result, up to 14 at a message end. Input bytes
//   are taken every cycle while the two-entry job queue has room, so the front
//   end runs ahead of a long reply. When the receiver stalls, the output
//   register holds and the queue fills; o_in_ready then drops until a job leaves
//   the queue. Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data
//   by the user only while the block is idle; the block does not enforce this.
//   Reset clears the parser, empties the queue and output, and loads the
//   register defaults; forwarding starts enabled.
// ----------------------------------------------------------------------------
module midi_sysex_command_parser_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [msx_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [msx_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_midi_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_tx_valid,
    output logic [7:0]                      o_tx_byte,
    output logic                            o_forward_enable,
    output logic                            o_last
);
    import msx_pkg::*;

    t_cfg r_cfg;
    logic f_job_valid;
    t_job f_job;
    logic q_ready;
    logic q_valid;
    t_job q_job;
    logic b_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_id            <= 7'd0;
            r_cfg.merger_mode_on       <= 1'b0;
            r_cfg.invalid_command_code <= 7'd12;
            r_cfg.grid_columns         <= 7'd16;
            r_cfg.grid_rows            <= 7'd16;
            r_cfg.led_colours          <= 7'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DEVICE_ID:      r_cfg.device_id            <= i_cfg_data;
                REG_MERGER_MODE_ON: r_cfg.merger_mode_on       <= i_cfg_data[0];
                REG_INVALID_CMD:    r_cfg.invalid_command_code <= i_cfg_data;
                REG_GRID_COLUMNS:   r_cfg.grid_columns         <= i_cfg_data;
                REG_GRID_ROWS:      r_cfg.grid_rows            <= i_cfg_data;
                REG_LED_COLOURS:    r_cfg.led_colours          <= i_cfg_data;
                default:            r_cfg                      <= r_cfg;
            endcase
        end
    end

    msx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_midi_byte (i_midi_byte),
        .o_job_valid (f_job_valid),
        .o_job       (f_job),
        .i_job_ready (q_ready)
    );

    msx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_job_valid),
        .o_ready (q_ready),
        .i_job   (f_job),
        .o_valid (q_valid),
        .i_ready (b_ready),
        .o_job   (q_job)
    );

    msx_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_job_valid      (q_valid),
        .o_job_ready      (b_ready),
        .i_job            (q_job),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_tx_valid       (o_tx_valid),
        .o_tx_byte        (o_tx_byte),
        .o_forward_enable (o_forward_enable),
        .o_last           (o_last)
    );

endmodule

### rtl/core/msx_checker.sv
// ----------------------------------------------------------------------------
// MIDI SysEx parser port checker
// Watches the output channel of the parser core over time.
// ----------------------------------------------------------------------------
module msx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_tx_valid,
    input logic [7:0] o_tx_byte,
    input logic       o_forward_enable,
    input logic       o_last
);

    // A stalled result stays offered and unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_tx_byte) && $stable(o_last) && $stable(o_tx_valid))
        else $error("output result changed while stalled");

    // An idle result is always the only result of its byte.
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_tx_valid |-> o_last)
        else $error("idle result not marked last");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_tx_valid |-> o_tx_byte == 8'h00)
        else $error("idle result carries a byte");

    // Forwarding state is fixed for all results of one byte.
    a_fwd_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last ##1 o_out_valid |->
            o_forward_enable == $past(o_forward_enable))
        else $error("forwarding changed inside a reply");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind midi_sysex_command_parser_core msx_checker u_msx_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_tx_valid       (o_tx_valid),
    .o_tx_byte        (o_tx_byte),
    .o_forward_enable (o_forward_enable),
    .o_last           (o_last)
);

### test/tb_midi_sysex_command_parser_core.sv
// ----------------------------------------------------------------------------
// Testbench for the MIDI SysEx command parser core
// Feeds MIDI byte streams (well-formed SysEx commands, broken headers, stray
// status bytes, realtime bytes and noise) through the valid/ready input, and
// checks every output transfer against a predictor of the parser and its
// reply sender. Configuration changes between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_midi_sysex_command_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    import msx_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 115;
    localparam int NUM_PHASES = 4;

    localparam logic [7:0] HDR_SEQ [0:4] = '{SYX_START, 8'h00, 8'h00, MFR_ID, DEV_FAMILY};
    localparam logic [CFG_IDX_W-1:0] REG_ORDER [0:5] = '{REG_DEVICE_ID, REG_MERGER_MODE_ON,
        REG_INVALID_CMD, REG_GRID_COLUMNS, REG_GRID_ROWS, REG_LED_COLOURS};

    typedef struct {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       fwd;
        logic       last;
    } tx_result_t;

    typedef enum int {STEP_OPEN, STEP_BODY, STEP_CLOSE} cmd_step_t;

    // Tracks the parser state and holds the reply transfers still owed.
    class reply_tracker;
        logic [6:0] dev_id, inv_code, cols, rows, colours;
        logic       merger;
        logic [2:0] hdr_pos;
        logic       in_msg, cmd_seen, pay_seen, fwd_on, tail_due;
        logic [6:0] cmd_code;
        logic [7:0] tx_bytes[$];
        tx_result_t replies[$];
        int         errors;

        function new();
            dev_id = '0;
            merger = 1'b0;
            inv_code = 7'd12;
            cols = 7'd16;
            rows = 7'd16;
            colours = 7'd2;
            tail_due = 1'b0;
            errors = 0;
            end_message();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [6:0] val);
            case (idx)
                REG_DEVICE_ID:      dev_id = val;
                REG_MERGER_MODE_ON: merger = val[0];
                REG_INVALID_CMD:    inv_code = val;
                REG_GRID_COLUMNS:   cols = val;
                REG_GRID_ROWS:      rows = val;
                REG_LED_COLOURS:    colours = val;
                default: ;
            endcase
        endfunction

        function void end_message();
            hdr_pos = '0;
            in_msg = 1'b0;
            cmd_seen = 1'b0;
            cmd_code = '0;
            pay_seen = 1'b0;
            fwd_on = 1'b1;
        endfunction

        function void put_footer();
            if (merger) tx_bytes.push_back(SYX_END);
        endfunction

        function void put_head();
            foreach (HDR_SEQ[i]) tx_bytes.push_back(HDR_SEQ[i]);
            tx_bytes.push_back({1'b0, dev_id});
        endfunction

        function void put_reply(logic [7:0] code, logic [7:0] arg);
            put_head();
            tx_bytes.push_back(code);
            tx_bytes.push_back(arg);
            tx_bytes.push_back(SYX_END);
        endfunction

        function void put_layout();
            put_head();
            tx_bytes.push_back(LAYOUT_ONE);
            tx_bytes.push_back({1'b0, cols});
            tx_bytes.push_back({1'b0, rows});
            tx_bytes.push_back({1'b0, colours});
            repeat (3) tx_bytes.push_back(LAYOUT_ONE);
            tx_bytes.push_back(SYX_END);
        endfunction

        function void run_command(cmd_step_t step);
            case (cmd_code)
                CMD_LAYOUT: begin
                    if (step == STEP_CLOSE) begin
                        put_footer();
                        put_layout();
                    end
                end
                CMD_NOP, CMD_DISACK: ;
                CMD_ACK: begin
                    if (step == STEP_OPEN) begin
                        pay_seen = 1'b0;
                    end else if (step == STEP_BODY) begin
                        pay_seen = 1'b1;
                    end else begin
                        put_footer();
                        if (!pay_seen) put_reply({1'b0, CMD_ACK}, 8'h00);
                    end
                end
                default: begin
                    // Unknown commands are refused on the spot.
                    put_footer();
                    put_reply({1'b0, CMD_DISACK}, {1'b0, inv_code});
                    end_message();
                end
            endcase
        endfunction

        function void parse(logic [7:0] b);
            logic bad;
            if (b >= RT_MIN) return;
            if (!in_msg) begin
                if (hdr_pos < HDR_LEN) bad = (b != HDR_SEQ[hdr_pos]);
                else bad = (b != {1'b0, dev_id});
                if (bad) begin
                    end_message();
                end else if (hdr_pos >= HDR_LEN) begin
                    hdr_pos = HDR_DONE;
                    in_msg = 1'b1;
                    fwd_on = 1'b0;
                end else begin
                    hdr_pos = hdr_pos + 3'd1;
                end
            end else if (b[7]) begin
                if (b == SYX_END && cmd_seen) run_command(STEP_CLOSE);
                end_message();
            end else if (!cmd_seen) begin
                cmd_seen = 1'b1;
                cmd_code = b[6:0];
                run_command(STEP_OPEN);
            end else begin
                run_command(STEP_BODY);
            end
        endfunction

        function void take_midi_byte(logic [7:0] b);
            tx_result_t r;
            int n;
            tx_bytes.delete();
            if (tail_due) begin
                tx_bytes.push_back(SYX_END);
                tail_due = 1'b0;
            end
            parse(b);
            // A reply longer than one burst carries its closing byte over.
            if (tx_bytes.size() > int'(MAX_ITEMS)) begin
                tail_due = 1'b1;
                n = int'(MAX_ITEMS);
            end else begin
                n = tx_bytes.size();
            end
            if (n == 0) begin
                r = '{1'b0, 8'h00, fwd_on, 1'b1};
                replies.push_back(r);
            end
            for (int k = 0; k < n; k++) begin
                r = '{1'b1, tx_bytes[k], fwd_on, k == n - 1};
                replies.push_back(r);
            end
        endfunction

        function void match_result(logic tv, logic [7:0] tb, logic fe, logic ls);
            tx_result_t e;
            if (replies.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: tx_valid %0b tx_byte %02h fwd %0b last %0b",
                         $time, tv, tb, fe, ls);
                return;
            end
            e = replies.pop_front();
            if (e.tx_valid !== tv || e.tx_byte !== tb || e.fwd !== fe || e.last !== ls) begin
                errors++;
                $display("%0t: expected tx_valid %0b tx_byte %02h fwd %0b last %0b", $time,
                         e.tx_valid, e.tx_byte, e.fwd, e.last);
                $display("%0t: actual   tx_valid %0b tx_byte %02h fwd %0b last %0b", $time,
                         tv, tb, fe, ls);
            end
        endfunction

        function int pending();
            return replies.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic [7:0]            i_midi_byte = '0;
    logic                  i_out_ready = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_tx_valid;
    logic [7:0]            o_tx_byte;
    logic                  o_forward_enable;
    logic                  o_last;

    reply_tracker sb;
    logic [6:0]   reg_val [0:5];
    logic [7:0]   msg_bytes[$];
    logic         quiet = 1'b0;
    logic         hold_req = 1'b0;
    int           idle_cycles = 0;

    midi_sysex_command_parser_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_midi_byte     (i_midi_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_tx_valid      (o_tx_valid),
        .o_tx_byte       (o_tx_byte),
        .o_forward_enable(o_forward_enable),
        .o_last          (o_last)
    );

    always #6 i_clk = ~i_clk;

    // Results are checked before the input of the same edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.match_result(o_tx_valid, o_tx_byte, o_forward_enable, o_last);
            if (i_in_valid && o_in_ready)
                sb.take_midi_byte(i_midi_byte);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_midi_sysex_command_parser_core: errors");
                $finish;
            end
        end
    end

    // Receiver: random stalls, one long hold-off on request, none when quiet.
    initial begin
        int unsigned n;
        bit held;
        held = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                n = HOLD_CYCLES;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                n = $urandom_range(1, 17);
            end else begin
                i_out_ready <= 1'b1;
                n = $urandom_range(1, 24);
            end
            repeat (n) @(posedge i_clk);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        i_in_valid <= 1'b1;
        i_midi_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        if (!quiet && $urandom_range(0, 11) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic send_all();
        foreach (msg_bytes[i]) send_byte(msg_bytes[i]);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_regs();
        for (int i = 0; i < 6; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= REG_ORDER[i];
            i_cfg_data <= reg_val[i];
            sb.set_reg(REG_ORDER[i], reg_val[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [6:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return 7'd0;
            1:       return 7'h7F;
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    task automatic push_header();
        foreach (HDR_SEQ[i]) msg_bytes.push_back(HDR_SEQ[i]);
    endtask

    // Mostly complete commands for this device, some cut short, some noise.
    task automatic build_message();
        int unsigned kind, n, cut;
        logic [6:0] cmd;
        msg_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            push_header();
            msg_bytes.push_back({1'b0, reg_val[0]});
            case ($urandom_range(0, 5))
                0:       cmd = CMD_LAYOUT;
                1:       cmd = CMD_NOP;
                2:       cmd = CMD_DISACK;
                3, 4:    cmd = CMD_ACK;
                default: cmd = 7'($urandom_range(0, 127));
            endcase
            msg_bytes.push_back({1'b0, cmd});
            n = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
            repeat (n) msg_bytes.push_back(8'($urandom_range(0, 127)));
            if ($urandom_range(0, 9) < 8) msg_bytes.push_back(SYX_END);
            else msg_bytes.push_back(8'($urandom_range(8'h80, 8'hF7)));
        end else if (kind < 85) begin
            cut = $urandom_range(0, 5);
            for (int i = 0; i < cut; i++) msg_bytes.push_back(HDR_SEQ[i]);
            msg_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 4)) msg_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0)
            msg_bytes.insert($urandom_range(0, msg_bytes.size()),
                             8'($urandom_range(RT_MIN, 8'hFF)));
    endtask

    initial begin
        int sent;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default registers: a layout request for device 0.
        msg_bytes = '{SYX_START, 8'h00, 8'h00, MFR_ID, DEV_FAMILY, 8'h00,
                      {1'b0, CMD_LAYOUT}, SYX_END};
        send_all();
        wait_drained();

        // Extreme registers with the merger footer: the layout reply overflows
        // one burst and its closing byte rides on the following realtime byte.
        reg_val = '{7'h7F, 7'd1, 7'h7F, 7'd0, 7'h7F, 7'd0};
        load_regs();
        msg_bytes = '{SYX_START, 8'h00, 8'h00, MFR_ID, DEV_FAMILY, 8'h7F,
                      {1'b0, CMD_LAYOUT}, SYX_END, 8'hFF,
                      SYX_START, 8'h00, 8'h00, MFR_ID, DEV_FAMILY, 8'h7F, 8'h7F,
                      SYX_START, 8'h05};
        send_all();
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            foreach (reg_val[i]) reg_val[i] = pick_value();
            reg_val[1] = 7'(p % 2);
            load_regs();
            if (p == 1) hold_req <= 1'b1;
            if (p == NUM_PHASES - 1) quiet <= 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                build_message();
                send_all();
                foreach (msg_bytes[i]) if (msg_bytes[i] < RT_MIN) sent++;
                if (p == 2 && sent >= PHASE_ITEMS / 2 && sent < PHASE_ITEMS / 2 + 8)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (16) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_midi_sysex_command_parser_core: clean");
        else
            $display("tb_midi_sysex_command_parser_core: errors");
        $finish;
    end

endmodule
